// ===== rtl/ia_pkg.sv =====
package ia_pkg;

	// default operand width
	localparam int IA_WIDTH_DEF = 32;

	// per-stage advance enables handed to the corner multipliers
	typedef struct packed {
		logic s2;
		logic s3;
	} ia_adv_t;

endpackage

// ===== rtl/ia_mag_mul.sv =====
// Two-stage unsigned WIDTH x WIDTH multiply: half-word partial products, then sum.
module ia_mag_mul import ia_pkg::*; #(
	parameter int WIDTH = IA_WIDTH_DEF
) (
	input  logic               clk,
	input  ia_adv_t            adv,
	input  logic [WIDTH-1:0]   x,
	input  logic [WIDTH-1:0]   y,
	output logic [2*WIDTH-1:0] prod
);

	localparam int LW = (WIDTH + 1) / 2;
	localparam int HW = WIDTH - LW;
	localparam int PW = 2 * WIDTH;

	logic [LW-1:0]      x0, y0;
	logic [HW-1:0]      x1, y1;
	logic [2*LW-1:0]    pp00_s2;
	logic [WIDTH-1:0]   pp01_s2, pp10_s2;
	logic [2*HW-1:0]    pp11_s2;
	logic [PW-1:0]      prod_s3;

	assign x0 = x[LW-1:0];
	assign x1 = x[WIDTH-1:LW];
	assign y0 = y[LW-1:0];
	assign y1 = y[WIDTH-1:LW];

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			pp00_s2 <= {{LW{1'b0}}, x0} * {{LW{1'b0}}, y0};
			pp01_s2 <= {{HW{1'b0}}, x0} * {{LW{1'b0}}, y1};
			pp10_s2 <= {{LW{1'b0}}, x1} * {{HW{1'b0}}, y0};
			pp11_s2 <= {{HW{1'b0}}, x1} * {{HW{1'b0}}, y1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			prod_s3 <= {{(PW-2*LW){1'b0}}, pp00_s2}
				+ ({{(PW-WIDTH){1'b0}}, pp01_s2} << LW)
				+ ({{(PW-WIDTH){1'b0}}, pp10_s2} << LW)
				+ {pp11_s2, {(2*LW){1'b0}}};
		end
	end

	assign prod = prod_s3;

endmodule

// ===== rtl/interval_arith_overflow_checked.sv =====
// Channel   Dir  tdata (low bit up)                         tuser
// s_*       in   a_low, a_high, b_low, b_high (WIDTH each)   cmd[1:0]
// m_*       out  res_low, res_high (WIDTH each)              status[1:0]
//
// Five-stage pipeline, one word in and one word out per cycle when unstalled;
// the stages are validity with add/sub/negate and magnitudes, the split corner
// partial products, sum, sign/range check, and min/max into the output register.
// arst_n clears only the stage valid bits; payload registers are not reset.
// Each stage holds only while it is full and the stage below it is stalled, so s_tready
// drops only when every stage is full and m_tready is low.
module interval_arith_overflow_checked import ia_pkg::*; #(
	parameter int WIDTH = IA_WIDTH_DEF,
	localparam int IN_DW  = ((4 * WIDTH + 7) / 8) * 8,
	localparam int OUT_DW = ((2 * WIDTH + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_DW-1:0]  s_tdata,   // a_low, a_high, b_low, b_high, zero pad
	input  logic [1:0]        s_tuser,   // cmd
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata,   // res_low, res_high, zero pad
	output logic [1:0]        m_tuser    // status
);

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_NEG = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OVF = 2'd1,
		ST_INV = 2'd2
	} status_t;

	localparam int PW = 2 * WIDTH;
	localparam logic [WIDTH-1:0] SIGN_MIN = {1'b1, {(WIDTH-1){1'b0}}};
	localparam logic [WIDTH-1:0] POS_MAX  = {1'b0, {(WIDTH-1){1'b1}}};

	// ---------------- handshake / stage advance ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;
	ia_adv_t mul_adv;

	assign adv5 = !v_s5 || m_tready;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_tready = adv1;
	assign mul_adv.s2 = adv2;
	assign mul_adv.s3 = adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: validity, add/sub/negate, magnitudes ----------------
	logic signed [WIDTH-1:0] op_in [4];   // a_low, a_high, b_low, b_high
	cmd_t                    cmd_in;
	logic                    inv_in;
	logic signed [WIDTH:0]   lx_lo, ly_lo, lx_hi, ly_hi, lr_lo, lr_hi;
	logic                    lsub;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			op_in[i] = s_tdata[i*WIDTH +: WIDTH];
		end
	end

	assign cmd_in = cmd_t'(s_tuser);
	assign inv_in = (op_in[0] > op_in[1]) || ((cmd_in != CMD_NEG) && (op_in[2] > op_in[3]));

	always_comb begin
		lx_lo = {op_in[0][WIDTH-1], op_in[0]};
		lx_hi = {op_in[1][WIDTH-1], op_in[1]};
		ly_lo = {op_in[2][WIDTH-1], op_in[2]};
		ly_hi = {op_in[3][WIDTH-1], op_in[3]};
		lsub  = 1'b0;
		unique case (cmd_in)
			CMD_ADD, CMD_MUL: begin
			end
			CMD_SUB: begin
				ly_lo = {op_in[3][WIDTH-1], op_in[3]};
				ly_hi = {op_in[2][WIDTH-1], op_in[2]};
				lsub  = 1'b1;
			end
			CMD_NEG: begin
				lx_lo = '0;
				lx_hi = '0;
				ly_lo = {op_in[1][WIDTH-1], op_in[1]};
				ly_hi = {op_in[0][WIDTH-1], op_in[0]};
				lsub  = 1'b1;
			end
		endcase
		lr_lo = lsub ? (lx_lo - ly_lo) : (lx_lo + ly_lo);
		lr_hi = lsub ? (lx_hi - ly_hi) : (lx_hi + ly_hi);
	end

	cmd_t             cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic             inv_s1, inv_s2, inv_s3, inv_s4;
	logic [WIDTH-1:0] lin_lo_s1, lin_lo_s2, lin_lo_s3, lin_lo_s4;
	logic [WIDTH-1:0] lin_hi_s1, lin_hi_s2, lin_hi_s3, lin_hi_s4;
	logic             lin_ovf_s1, lin_ovf_s2, lin_ovf_s3, lin_ovf_s4;
	logic [WIDTH-1:0] mag_s1 [4];
	logic [3:0]       neg_s1, neg_s2, neg_s3;

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1     <= cmd_in;
			inv_s1     <= inv_in;
			lin_lo_s1  <= lr_lo[WIDTH-1:0];
			lin_hi_s1  <= lr_hi[WIDTH-1:0];
			lin_ovf_s1 <= (lr_lo[WIDTH] != lr_lo[WIDTH-1]) || (lr_hi[WIDTH] != lr_hi[WIDTH-1]);
			for (int i = 0; i < 4; i++) begin
				mag_s1[i] <= op_in[i][WIDTH-1] ? (~op_in[i] + 1'b1) : op_in[i];
			end
			for (int k = 0; k < 4; k++) begin
				// corner k: a bound k/2, b bound k%2
				neg_s1[k] <= op_in[k/2][WIDTH-1] ^ op_in[2 + (k%2)][WIDTH-1];
			end
		end
	end

	// ---------------- stages 2-3: corner magnitude products ----------------
	logic [PW-1:0] prod_s3 [4];

	for (genvar k = 0; k < 4; k++) begin : g_corner
		ia_mag_mul #(
			.WIDTH(WIDTH)
		) u_mul (
			.clk  (clk),
			.adv  (mul_adv),
			.x    (mag_s1[k/2]),
			.y    (mag_s1[2 + (k%2)]),
			.prod (prod_s3[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			cmd_s2     <= cmd_s1;
			inv_s2     <= inv_s1;
			lin_lo_s2  <= lin_lo_s1;
			lin_hi_s2  <= lin_hi_s1;
			lin_ovf_s2 <= lin_ovf_s1;
			neg_s2     <= neg_s1;
		end
		if (adv3) begin
			cmd_s3     <= cmd_s2;
			inv_s3     <= inv_s2;
			lin_lo_s3  <= lin_lo_s2;
			lin_hi_s3  <= lin_hi_s2;
			lin_ovf_s3 <= lin_ovf_s2;
			neg_s3     <= neg_s2;
		end
	end

	// ---------------- stage 4: sign and range check per corner ----------------
	logic signed [WIDTH-1:0] cv_s4 [4];
	logic [3:0]              cov_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			cmd_s4     <= cmd_s3;
			inv_s4     <= inv_s3;
			lin_lo_s4  <= lin_lo_s3;
			lin_hi_s4  <= lin_hi_s3;
			lin_ovf_s4 <= lin_ovf_s3;
			for (int k = 0; k < 4; k++) begin
				// negative products may reach the most negative value
				cov_s4[k] <= (prod_s3[k][PW-1:WIDTH] != '0)
					|| (prod_s3[k][WIDTH-1:0] > (neg_s3[k] ? SIGN_MIN : POS_MAX));
				cv_s4[k]  <= neg_s3[k] ? (~prod_s3[k][WIDTH-1:0] + 1'b1)
					: prod_s3[k][WIDTH-1:0];
			end
		end
	end

	// ---------------- stage 5: min/max, status, output register ----------------
	logic signed [WIDTH-1:0] lo01, lo23, hi01, hi23, mmin, mmax;
	logic signed [WIDTH-1:0] res_low_d, res_high_d;
	status_t                 status_d;

	always_comb begin
		lo01 = (cv_s4[0] < cv_s4[1]) ? cv_s4[0] : cv_s4[1];
		hi01 = (cv_s4[0] > cv_s4[1]) ? cv_s4[0] : cv_s4[1];
		lo23 = (cv_s4[2] < cv_s4[3]) ? cv_s4[2] : cv_s4[3];
		hi23 = (cv_s4[2] > cv_s4[3]) ? cv_s4[2] : cv_s4[3];
		mmin = (lo01 < lo23) ? lo01 : lo23;
		mmax = (hi01 > hi23) ? hi01 : hi23;

		res_low_d  = '0;
		res_high_d = '0;
		priority if (inv_s4) begin
			status_d = ST_INV;
		end else if (cmd_s4 == CMD_MUL) begin
			if (cov_s4 != '0) begin
				status_d = ST_OVF;
			end else begin
				status_d   = ST_OK;
				res_low_d  = mmin;
				res_high_d = mmax;
			end
		end else if (lin_ovf_s4) begin
			status_d = ST_OVF;
		end else begin
			status_d   = ST_OK;
			res_low_d  = lin_lo_s4;
			res_high_d = lin_hi_s4;
		end
	end

	logic [WIDTH-1:0] res_low_s5, res_high_s5;
	status_t          status_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			res_low_s5  <= res_low_d;
			res_high_s5 <= res_high_d;
			status_s5   <= status_d;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = OUT_DW'({res_high_s5, res_low_s5});
	assign m_tuser  = status_s5;

	// ---------------- assertions ----------------
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled while pipeline not full");

	a_zero_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
		else $error("nonzero bounds with bad status");

	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_OK)) |-> ($signed(res_low_s5) <= $signed(res_high_s5)))
		else $error("result interval low above high");

	a_fill_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !v_s5) |=> v_s5)
		else $error("word did not move into empty output stage");

endmodule
